@@ sv/bvp_pkg.sv @@
package bvp_pkg;

   localparam int MAX_BITS_DEFAULT = 1024;
   localparam int SIZE_W = 11;
   localparam int INDEX_W = 10;
   localparam int KIND_W = 2;
   localparam int POP_W = 11;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   typedef enum logic [KIND_W-1:0] {
      KIND_SET   = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_TEST  = 2'd2,
      KIND_COUNT = 2'd3
   } kind_type;

   function automatic logic [3:0] byte_pop(input logic [7:0] b);
      logic [3:0] c;
      c = 4'd0;
      for (int k = 0; k < 8; k++) begin
         c = c + {3'd0, b[k]};
      end
      return c;
   endfunction

endpackage

@@ sv/bitmap_with_population_count.sv @@
// Channel   Direction  Handshake                Contents
// req_      in         req_tvalid/req_tready    tuser: kind; tdata: bit_index
// rsp_      out        rsp_tvalid/rsp_tready    tdata: bit_value, population; tuser: index_error
// csr_      in         csr_write                csr_wdata: vector_size
//
// Set and clear read the byte on acceptance, then modify it and write it back; test reads the bit.
// A count with a valid cache, and any index error, is answered straight from the idle state.
// A stale count walks the store one byte a cycle through its single read port, over the
// bytes that hold the size in use, masks the last partly used byte, then caches the total.
// After reset a clearing pass zeroes all (MAX_BITS + 7) / 8 bytes of the store before the
// first request is taken. A waiting response holds the block off.
module bitmap_with_population_count
   import bvp_pkg::*;
#(
   parameter int MAX_BITS = MAX_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // [9:0] bit_index, [15:10] zero
   input  logic [KIND_W-1:0] req_tuser,   // [1:0] kind
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // [0] bit_value, [11:1] population, [15:12] zero
   output logic              rsp_tuser,   // [0] index_error
   input  logic              csr_write,
   input  logic [SIZE_W-1:0] csr_wdata
);

   localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
   localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int CNT_W = $clog2(STORE_BYTES + 1);
   localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;
   localparam int SIZE_CAP = (MAX_BITS > 2047) ? 2047 : MAX_BITS;
   localparam logic [SIZE_W-1:0] SIZE_CAP_V = SIZE_W'(SIZE_CAP);
   localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(STORE_BYTES - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY,
      ST_COUNT
   } state_type;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [POP_W-1:0]  cached_ff, cached_in;
   logic              cache_valid_ff, cache_valid_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [POP_W-1:0]  acc_ff, acc_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]  rd_byte_ff, rd_byte_in;
   kind_type          kind_ff, kind_in;
   logic [2:0]        bitpos_ff, bitpos_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_bit_ff, rsp_bit_in;
   logic [POP_W-1:0]  rsp_pop_ff, rsp_pop_in;
   logic              rsp_err_ff, rsp_err_in;

   logic [7:0]        mem [STORE_BYTES];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   logic [SIZE_W-1:0] lim;
   logic [SIZE_W:0]   lim_round;
   logic [8:0]        nbytes;
   logic [7:0]        mask;
   logic [7:0]        bit_mask;
   logic              accept;
   logic              issue;
   logic              idx_bad;
   kind_type          req_kind;

   assign lim = (size_ff > SIZE_CAP_V) ? SIZE_CAP_V : size_ff;
   assign lim_round = {1'b0, lim} + (SIZE_W + 1)'(7);
   assign nbytes = lim_round[SIZE_W:3];
   assign req_kind = kind_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept = req_tvalid && req_tready;
   assign idx_bad = ({1'b0, req_tdata[INDEX_W-1:0]} >= lim);
   assign issue = (CMP_W'(cnt_ff) < CMP_W'(nbytes));
   assign bit_mask = 8'd1 << bitpos_ff;
   // Only the bits below the size in use count in the last, partly used byte.
   assign mask = (CMP_W'(rd_byte_ff) == CMP_W'(lim[SIZE_W-1:3]))
                 ? ((8'd1 << lim[2:0]) - 8'd1) : 8'hFF;

   always_comb begin
      state_in = state_ff;
      size_in = size_ff;
      cached_in = cached_ff;
      cache_valid_in = cache_valid_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      rd_vld_in = 1'b0;
      rd_byte_in = rd_byte_ff;
      kind_in = kind_ff;
      bitpos_in = bitpos_ff;
      addr_in = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_bit_in = rsp_bit_ff;
      rsp_pop_in = rsp_pop_ff;
      rsp_err_in = rsp_err_ff;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = cnt_ff[ADDR_W-1:0];
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_BYTE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_kind;
               bitpos_in = req_tdata[2:0];
               addr_in = ADDR_W'(req_tdata[INDEX_W-1:3]);
               rd_addr = ADDR_W'(req_tdata[INDEX_W-1:3]);
               rsp_bit_in = 1'b0;
               rsp_pop_in = '0;
               rsp_err_in = 1'b0;
               if (req_kind == KIND_COUNT) begin
                  if (cache_valid_ff) begin
                     rsp_pop_in = cached_ff;
                     rsp_valid_in = 1'b1;
                  end else begin
                     cnt_in = '0;
                     acc_in = '0;
                     state_in = ST_COUNT;
                  end
               end else if (idx_bad) begin
                  rsp_err_in = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_MODIFY;
               end
            end
         end
         ST_MODIFY: begin
            wr_addr = addr_ff;
            unique case (kind_ff)
               KIND_SET: begin
                  wr_en = 1'b1;
                  wr_data = rd_data_ff | bit_mask;
                  cache_valid_in = 1'b0;
               end
               KIND_CLEAR: begin
                  wr_en = 1'b1;
                  wr_data = rd_data_ff & ~bit_mask;
                  cache_valid_in = 1'b0;
               end
               KIND_TEST: begin
                  rsp_bit_in = |(rd_data_ff & bit_mask);
               end
               KIND_COUNT: begin
                  rsp_bit_in = 1'b0;
               end
            endcase
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_COUNT: begin
            if (issue) begin
               rd_addr = cnt_ff[ADDR_W-1:0];
               cnt_in = cnt_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
               rd_byte_in = cnt_ff;
            end
            if (rd_vld_ff) begin
               acc_in = acc_ff + POP_W'(byte_pop(rd_data_ff & mask));
            end
            if (!issue && !rd_vld_ff) begin
               cached_in = acc_ff;
               cache_valid_in = 1'b1;
               rsp_pop_in = acc_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase

      if (csr_write) begin
         size_in = csr_wdata;
         cache_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         size_ff <= SIZE_RESET;
         cached_ff <= '0;
         cache_valid_ff <= 1'b0;
         cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff <= size_in;
         cached_ff <= cached_in;
         cache_valid_ff <= cache_valid_in;
         cnt_ff <= cnt_in;
         rd_vld_ff <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff <= acc_in;
      rd_byte_ff <= rd_byte_in;
      kind_ff <= kind_in;
      bitpos_ff <= bitpos_in;
      addr_ff <= addr_in;
      rsp_bit_ff <= rsp_bit_in;
      rsp_pop_ff <= rsp_pop_in;
      rsp_err_ff <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'd0, rsp_pop_ff, rsp_bit_ff};
   assign rsp_tuser = rsp_err_ff;

endmodule

@@ tb/tb_bitmap_with_population_count.sv @@
module tb_bitmap_with_population_count;
   import bvp_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int STORE_BYTES = MAX_BITS_DEFAULT / 8;

   typedef struct packed {
      logic             bit_value;
      logic [POP_W-1:0] population;
      logic             index_error;
   } answer_type;

   class bitmap_scoreboard;
      logic [7:0]       bitmap [STORE_BYTES];
      logic [SIZE_W-1:0] size_reg;
      logic [POP_W-1:0] cached_count;
      bit               count_fresh;
      answer_type       expected_answers [$];
      int               mismatches;
      int               responses_seen;

      function new();
         foreach (bitmap[i]) bitmap[i] = 8'h00;
         size_reg = SIZE_RESET;
         cached_count = '0;
         count_fresh = 1'b0;
         mismatches = 0;
         responses_seen = 0;
      endfunction

      function int bits_in_use();
         return (size_reg > MAX_BITS_DEFAULT) ? MAX_BITS_DEFAULT : int'(size_reg);
      endfunction

      function void write_size(logic [SIZE_W-1:0] value);
         size_reg = value;
         count_fresh = 1'b0;
      endfunction

      // Bits kept above a reduced size are left out of the count.
      function logic [POP_W-1:0] count_set_bits();
         logic [POP_W-1:0] total;
         total = '0;
         for (int i = 0; i < bits_in_use(); i++) begin
            total = total + bitmap[i / 8][i % 8];
         end
         return total;
      endfunction

      function void note_request(kind_type kind, logic [INDEX_W-1:0] index);
         answer_type answer;
         answer = '0;
         if (kind == KIND_COUNT) begin
            if (!count_fresh) begin
               cached_count = count_set_bits();
               count_fresh = 1'b1;
            end
            answer.population = cached_count;
         end else if (int'(index) >= bits_in_use()) begin
            answer.index_error = 1'b1;
         end else begin
            case (kind)
               KIND_SET: begin
                  bitmap[index[INDEX_W-1:3]][index[2:0]] = 1'b1;
                  count_fresh = 1'b0;
               end
               KIND_CLEAR: begin
                  bitmap[index[INDEX_W-1:3]][index[2:0]] = 1'b0;
                  count_fresh = 1'b0;
               end
               default: begin
                  answer.bit_value = bitmap[index[INDEX_W-1:3]][index[2:0]];
               end
            endcase
         end
         expected_answers.push_back(answer);
      endfunction

      function void check_response(logic [15:0] data, logic user);
         answer_type wanted;
         responses_seen++;
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d arrived with no request outstanding", responses_seen);
            return;
         end
         wanted = expected_answers.pop_front();
         if (data[0] !== wanted.bit_value || data[POP_W:1] !== wanted.population ||
             user !== wanted.index_error) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d: expected %0d %0d %0d, got %0d %0d %0d",
                        responses_seen, wanted.bit_value, wanted.population,
                        wanted.index_error, data[0], data[POP_W:1], user);
         end
      endfunction

      function int pending();
         return expected_answers.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;
   logic [KIND_W-1:0]   req_tuser = KIND_SET;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;
   logic                rsp_tuser;
   logic                csr_write = 1'b0;
   logic [SIZE_W-1:0]   csr_wdata = '0;

   int                  send_idle_pct = 27;
   int                  recv_idle_pct = 71;
   int                  quiet_cycles = 0;

   bitmap_scoreboard    mirror = new();

   bitmap_with_population_count dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_write  (csr_write),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            mirror.note_request(kind_type'(req_tuser), req_tdata[INDEX_W-1:0]);
         if (rsp_tvalid && rsp_tready)
            mirror.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // The count restarts on every handshake; the clearing pass after reset stays well inside it.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // This task lowers the valid line only while idling, so back-to-back requests keep it high.
   task automatic send_request(input kind_type kind, input logic [INDEX_W-1:0] index);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {{(16 - INDEX_W){1'b0}}, index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(input int span);
      kind_type kind;
      logic [INDEX_W-1:0] index;
      int pick;
      pick = $urandom_range(99);
      kind = (pick < 35) ? KIND_SET : (pick < 55) ? KIND_CLEAR :
             (pick < 82) ? KIND_TEST : KIND_COUNT;
      // Mostly indices in range, with some anywhere in the field to provoke errors.
      if (span > 0 && $urandom_range(9) < 8)
         index = INDEX_W'($urandom_range(span - 1));
      else
         index = INDEX_W'($urandom_range((1 << INDEX_W) - 1));
      send_request(kind, index);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (mirror.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] value);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      mirror.write_size(value);
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(input logic [SIZE_W-1:0] size, input int requests,
                            input int send_pct, input int recv_pct);
      int span;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      span = (size > MAX_BITS_DEFAULT) ? MAX_BITS_DEFAULT : int'(size);
      write_size(size);
      repeat (requests) send_random(span);
      drain();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed requests at the reset size, starting from a stale cache.
      send_request(KIND_COUNT, 10'd0);
      send_request(KIND_SET, 10'd0);
      send_request(KIND_SET, 10'd1023);
      send_request(KIND_TEST, 10'd0);
      send_request(KIND_TEST, 10'd1023);
      send_request(KIND_TEST, 10'd512);
      send_request(KIND_COUNT, 10'd1023);
      send_request(KIND_COUNT, 10'd341);
      send_request(KIND_CLEAR, 10'd0);
      send_request(KIND_CLEAR, 10'd0);
      send_request(KIND_TEST, 10'd0);
      send_request(KIND_COUNT, 10'd682);
      send_request(KIND_SET, 10'd1023);
      send_request(KIND_SET, 10'd7);
      send_request(KIND_SET, 10'd8);
      send_request(KIND_COUNT, 10'd0);
      drain();

      run_phase(11'd1, 45, 27, 71);
      run_phase(11'd0, 25, 27, 71);
      run_phase(11'd13, 65, 27, 71);
      run_phase(11'd2047, 70, 71, 27);
      run_phase(11'd100, 60, 71, 27);
      run_phase(11'd1025, 70, 71, 27);
      run_phase(11'($urandom_range(1, 2047)), 65, 0, 0);
      run_phase(11'd1024, 80, 0, 0);
      run_phase(11'd37, 55, 0, 0);

      if (mirror.mismatches == 0 && mirror.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
